// File: rtl/fdax_pkg.sv
// Package for the fused dot product and axpy stream block.
// Holds the configuration and work item types and the queue and register constants.
`default_nettype none

package fdax_pkg;

    localparam int PROD_W  = 33;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = QPTR_W + 1;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_ALPHA_RE    = 3'd0;
    localparam logic [2:0] REG_ALPHA_IM    = 3'd1;
    localparam logic [2:0] REG_CONJ_DOT_X  = 3'd2;
    localparam logic [2:0] REG_CONJ_DOT_Y  = 3'd3;
    localparam logic [2:0] REG_CONJ_AXPY_X = 3'd4;

    typedef struct packed {
        logic signed [15:0] alpha_re;
        logic signed [15:0] alpha_im;
        logic               conj_dot_x;
        logic               conj_dot_y;
        logic               conj_axpy_x;
    } t_cfg;

    typedef struct packed {
        logic signed [PROD_W-1:0] axpy_re;
        logic signed [PROD_W-1:0] axpy_im;
        logic signed [PROD_W-1:0] dot_re;
        logic signed [PROD_W-1:0] dot_im;
        logic signed [15:0]       z_re;
        logic signed [15:0]       z_im;
        logic                     last;
    } t_work;

endpackage

`default_nettype wire

// File: rtl/fdax_if.sv
// Stream interfaces for the fused dot product and axpy block.
// Input item channel and result item channel; no dependencies.
`default_nettype none

interface fdax_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_re;
    logic signed [15:0] x_im;
    logic signed [15:0] y_re;
    logic signed [15:0] y_im;
    logic signed [15:0] z_re;
    logic signed [15:0] z_im;
    logic               last;

    modport source (output valid, x_re, x_im, y_re, y_im, z_re, z_im, last, input ready);
    modport sink (input valid, x_re, x_im, y_re, y_im, z_re, z_im, last, output ready);
endinterface

interface fdax_out_if #(
    parameter int ACC_WIDTH = 48
);
    logic                        valid;
    logic                        ready;
    logic signed [15:0]          z_new_re;
    logic signed [15:0]          z_new_im;
    logic signed [ACC_WIDTH-1:0] dot_re;
    logic signed [ACC_WIDTH-1:0] dot_im;
    logic                        dot_valid;

    modport source (output valid, z_new_re, z_new_im, dot_re, dot_im, dot_valid, input ready);
    modport sink (input valid, z_new_re, z_new_im, dot_re, dot_im, dot_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/fdax_regs.sv
// Configuration registers behind an APB-style port.
// Depends on fdax_pkg for the register codes and the configuration struct.
`default_nettype none

module fdax_regs
    import fdax_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (paddr[4:2])
                REG_ALPHA_RE:    n_cfg.alpha_re    = pwdata[15:0];
                REG_ALPHA_IM:    n_cfg.alpha_im    = pwdata[15:0];
                REG_CONJ_DOT_X:  n_cfg.conj_dot_x  = pwdata[0];
                REG_CONJ_DOT_Y:  n_cfg.conj_dot_y  = pwdata[0];
                REG_CONJ_AXPY_X: n_cfg.conj_axpy_x = pwdata[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ALPHA_RE:    prdata = {{16{r_cfg.alpha_re[15]}}, r_cfg.alpha_re};
            REG_ALPHA_IM:    prdata = {{16{r_cfg.alpha_im[15]}}, r_cfg.alpha_im};
            REG_CONJ_DOT_X:  prdata = {31'd0, r_cfg.conj_dot_x};
            REG_CONJ_DOT_Y:  prdata = {31'd0, r_cfg.conj_dot_y};
            REG_CONJ_AXPY_X: prdata = {31'd0, r_cfg.conj_axpy_x};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fdax_front.sv
// Front stage: accepts input items and forms the axpy and dot product terms.
// Depends on fdax_pkg and fdax_in_if; feeds the work queue.
`default_nettype none

module fdax_front
    import fdax_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    fdax_in_if.sink   i_dat,
    output logic      o_push,
    output t_work     o_work,
    input  wire logic i_push_ready
);

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  w_accept;

    logic signed [PROD_W-1:0] w_a_re;
    logic signed [PROD_W-1:0] w_a_im;
    logic signed [PROD_W-1:0] w_xr;
    logic signed [PROD_W-1:0] w_xi;
    logic signed [PROD_W-1:0] w_yr;
    logic signed [PROD_W-1:0] w_yi;
    logic signed [PROD_W-1:0] w_ax;
    logic signed [PROD_W-1:0] w_dxi;
    logic signed [PROD_W-1:0] w_dyi;

    assign i_dat.ready = !r_valid || i_push_ready;
    assign w_accept    = i_dat.valid && i_dat.ready;
    assign o_push      = r_valid;
    assign o_work      = r_work;

    always_comb begin
        w_a_re = PROD_W'(i_cfg.alpha_re);
        w_a_im = PROD_W'(i_cfg.alpha_im);
        w_xr   = PROD_W'(i_dat.x_re);
        w_xi   = PROD_W'(i_dat.x_im);
        w_yr   = PROD_W'(i_dat.y_re);
        w_yi   = PROD_W'(i_dat.y_im);
        w_ax   = i_cfg.conj_axpy_x ? -w_xi : w_xi;
        w_dxi  = i_cfg.conj_dot_x ? -w_xi : w_xi;
        w_dyi  = i_cfg.conj_dot_y ? -w_yi : w_yi;

        n_work.axpy_re = w_a_re * w_xr - w_a_im * w_ax;
        n_work.axpy_im = w_a_re * w_ax + w_a_im * w_xr;
        n_work.dot_re  = w_xr * w_yr - w_dxi * w_dyi;
        n_work.dot_im  = w_xr * w_dyi + w_dxi * w_yr;
        n_work.z_re    = i_dat.z_re;
        n_work.z_im    = i_dat.z_im;
        n_work.last    = i_dat.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_work <= n_work;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fdax_queue.sv
// Short work queue between the front and back stages.
// Depends on fdax_pkg for the work item type and the queue depth.
`default_nettype none

module fdax_queue
    import fdax_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_work,
    output logic       o_push_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_work      o_work
);

    t_work              r_mem [QDEPTH];
    logic  [QPTR_W-1:0] r_wr_ptr;
    logic  [QPTR_W-1:0] r_rd_ptr;
    logic  [QCNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = r_count != QCNT_W'(QDEPTH);
    assign o_valid      = r_count != '0;
    assign o_work       = r_mem[r_rd_ptr];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not drop on pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCNT_W'(QDEPTH)) |-> ((r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: rtl/fdax_back.sv
// Back stage: rounds the axpy result, runs the saturating dot accumulator
// and holds the result item. Depends on fdax_pkg and fdax_out_if.
`default_nettype none

module fdax_back
    import fdax_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_work_valid,
    input  wire t_work i_work,
    output logic       o_pop,
    fdax_out_if.source o_res
);

    localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic                        r_valid;
    logic signed [15:0]          r_z_re;
    logic signed [15:0]          r_z_im;
    logic signed [ACC_WIDTH-1:0] r_dot_re;
    logic signed [ACC_WIDTH-1:0] r_dot_im;
    logic                        r_dot_valid;
    logic signed [ACC_WIDTH-1:0] r_acc_re;
    logic signed [ACC_WIDTH-1:0] r_acc_im;
    logic signed [ACC_WIDTH-1:0] n_acc_re;
    logic signed [ACC_WIDTH-1:0] n_acc_im;
    logic signed [15:0]          w_z_re;
    logic signed [15:0]          w_z_im;

    function automatic logic signed [15:0] round_sat(
        input logic signed [15:0]        z,
        input logic signed [PROD_W-1:0]  p
    );
        logic signed [PROD_W:0] sum;
        logic signed [PROD_W:0] rnd;
        begin
            sum = ((PROD_W + 1)'(z) <<< 15) + (PROD_W + 1)'(p) + (PROD_W + 1)'(16384);
            rnd = sum >>> 15;
            if (rnd > (PROD_W + 1)'(32767)) begin
                round_sat = 16'sh7fff;
            end else if (rnd < -(PROD_W + 1)'(32768)) begin
                round_sat = -16'sh8000;
            end else begin
                round_sat = rnd[15:0];
            end
        end
    endfunction

    function automatic logic signed [ACC_WIDTH-1:0] acc_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [PROD_W-1:0]    p
    );
        logic signed [ACC_WIDTH:0] sum;
        begin
            sum = (ACC_WIDTH + 1)'(a) + (ACC_WIDTH + 1)'(p);
            if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
                acc_add = sum[ACC_WIDTH] ? AccMin : AccMax;
            end else begin
                acc_add = sum[ACC_WIDTH-1:0];
            end
        end
    endfunction

    assign o_pop = i_work_valid && (!r_valid || o_res.ready);

    assign o_res.valid     = r_valid;
    assign o_res.z_new_re  = r_z_re;
    assign o_res.z_new_im  = r_z_im;
    assign o_res.dot_re    = r_dot_re;
    assign o_res.dot_im    = r_dot_im;
    assign o_res.dot_valid = r_dot_valid;

    always_comb begin
        w_z_re   = round_sat(i_work.z_re, i_work.axpy_re);
        w_z_im   = round_sat(i_work.z_im, i_work.axpy_im);
        n_acc_re = acc_add(r_acc_re, i_work.dot_re);
        n_acc_im = acc_add(r_acc_im, i_work.dot_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_acc_re <= i_work.last ? '0 : n_acc_re;
                r_acc_im <= i_work.last ? '0 : n_acc_im;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_z_re      <= w_z_re;
            r_z_im      <= w_z_im;
            r_dot_re    <= i_work.last ? n_acc_re : '0;
            r_dot_im    <= i_work.last ? n_acc_im : '0;
            r_dot_valid <= i_work.last;
        end
    end

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_work.last) |=> (r_acc_re == '0 && r_acc_im == '0))
        else $error("accumulator not cleared after last item");

    a_dot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_dot_valid) |-> (r_dot_re == '0 && r_dot_im == '0))
        else $error("dot fields set on an item that is not last");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (i_work_valid && (!r_valid || o_res.ready)))
        else $error("pop without room in the output register");

endmodule

`default_nettype wire

// File: rtl/fused_dot_axpy_stream.sv
// Fused complex dot product and axpy over a stream of Q1.15 elements.
// An accepted item passes the front register, a queue entry and the back register before result valid.
// One item per cycle unless the output stalls; front multiplies and back accumulator add are registered.
// A 4-entry queue between front and back absorbs output stalls.
// Synchronous active-low reset clears configuration, accumulator, queue and valid flags.
`default_nettype none

module fused_dot_axpy_stream
    import fdax_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    fdax_in_if.sink                 i_dat,
    fdax_out_if.source              o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    t_cfg  w_cfg;
    logic  w_push;
    logic  w_push_ready;
    t_work w_front_work;
    logic  w_q_valid;
    t_work w_q_work;
    logic  w_pop;

    fdax_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fdax_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_dat        (i_dat),
        .o_push       (w_push),
        .o_work       (w_front_work),
        .i_push_ready (w_push_ready)
    );

    fdax_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_work       (w_front_work),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_valid      (w_q_valid),
        .o_work       (w_q_work)
    );

    fdax_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_q_valid),
        .i_work       (w_q_work),
        .o_pop        (w_pop),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

// File: verif/fdax_checker.sv
// Scoreboard for the fused dot product and axpy stream block.
// Snoops the APB writes and both item channels, predicts each result item and compares it.
// Depends on fdax_pkg and the fdax_in_if and fdax_out_if interfaces.
`default_nettype none

module fdax_checker
    import fdax_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    fdax_in_if                      i_dat,
    fdax_out_if                     i_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int                      o_err_count,
    output int                      o_pending
);

    localparam int     ACC_W      = 48;
    localparam longint ACC_MAX    = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_MIN    = -ACC_MAX - 64'sd1;
    localparam int     PRINT_MAX  = 40;

    typedef struct {
        logic signed [15:0]      z_re;
        logic signed [15:0]      z_im;
        logic signed [ACC_W-1:0] dot_re;
        logic signed [ACC_W-1:0] dot_im;
        logic                    dot_valid;
    } t_z_dot;

    t_cfg   cfg;
    longint acc_re;
    longint acc_im;
    t_z_dot pending_updates[$];

    function automatic logic signed [15:0] round_q15(longint zv, longint prod);
        longint v;
        v = (zv * 32768 + prod + 16384) >>> 15;
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    function automatic longint acc_sat_add(longint a, longint p);
        longint s;
        s = a + p;
        if (s > ACC_MAX) begin
            return ACC_MAX;
        end
        if (s < ACC_MIN) begin
            return ACC_MIN;
        end
        return s;
    endfunction

    function automatic t_z_dot predict_update(
        input logic signed [15:0] x_re,
        input logic signed [15:0] x_im,
        input logic signed [15:0] y_re,
        input logic signed [15:0] y_im,
        input logic signed [15:0] z_re,
        input logic signed [15:0] z_im,
        input logic               lst
    );
        t_z_dot r;
        longint xr, xi, yr, yi, ar, ai, ax, dxi, dyi;
        xr  = x_re;
        xi  = x_im;
        yr  = y_re;
        yi  = y_im;
        ar  = $signed(cfg.alpha_re);
        ai  = $signed(cfg.alpha_im);
        ax  = cfg.conj_axpy_x ? -xi : xi;
        dxi = cfg.conj_dot_x ? -xi : xi;
        dyi = cfg.conj_dot_y ? -yi : yi;
        r.z_re = round_q15(longint'(z_re), ar * xr - ai * ax);
        r.z_im = round_q15(longint'(z_im), ar * ax + ai * xr);
        acc_re = acc_sat_add(acc_re, xr * yr - dxi * dyi);
        acc_im = acc_sat_add(acc_im, xr * dyi + dxi * yr);
        r.dot_valid = lst;
        if (lst) begin
            r.dot_re = acc_re[ACC_W-1:0];
            r.dot_im = acc_im[ACC_W-1:0];
            acc_re   = 0;
            acc_im   = 0;
        end else begin
            r.dot_re = '0;
            r.dot_im = '0;
        end
        return r;
    endfunction

    task automatic report_error(string msg);
        if (o_err_count < PRINT_MAX) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        o_err_count++;
    endtask

    always @(posedge i_clk) begin
        t_z_dot want;
        if (!i_rst_n) begin
            cfg    = '0;
            acc_re = 0;
            acc_im = 0;
            pending_updates.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_updates.size() == 0) begin
                    report_error("result item with no item outstanding");
                end else begin
                    want = pending_updates.pop_front();
                    if (i_res.z_new_re !== want.z_re) begin
                        report_error($sformatf("z_new_re got %0d expected %0d",
                            i_res.z_new_re, want.z_re));
                    end
                    if (i_res.z_new_im !== want.z_im) begin
                        report_error($sformatf("z_new_im got %0d expected %0d",
                            i_res.z_new_im, want.z_im));
                    end
                    if (i_res.dot_re !== want.dot_re) begin
                        report_error($sformatf("dot_re got %0d expected %0d",
                            i_res.dot_re, want.dot_re));
                    end
                    if (i_res.dot_im !== want.dot_im) begin
                        report_error($sformatf("dot_im got %0d expected %0d",
                            i_res.dot_im, want.dot_im));
                    end
                    if (i_res.dot_valid !== want.dot_valid) begin
                        report_error($sformatf("dot_valid got %0b expected %0b",
                            i_res.dot_valid, want.dot_valid));
                    end
                end
            end
            if (i_dat.valid && i_dat.ready) begin
                pending_updates.push_back(predict_update(i_dat.x_re, i_dat.x_im,
                    i_dat.y_re, i_dat.y_im, i_dat.z_re, i_dat.z_im, i_dat.last));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_ALPHA_RE:    cfg.alpha_re    = pwdata[15:0];
                    REG_ALPHA_IM:    cfg.alpha_im    = pwdata[15:0];
                    REG_CONJ_DOT_X:  cfg.conj_dot_x  = pwdata[0];
                    REG_CONJ_DOT_Y:  cfg.conj_dot_y  = pwdata[0];
                    REG_CONJ_AXPY_X: cfg.conj_axpy_x = pwdata[0];
                    default: ;
                endcase
            end
        end
        o_pending <= pending_updates.size();
    end

endmodule

`default_nettype wire

// File: verif/fused_dot_axpy_stream_tb.sv
// Top of the fused dot product and axpy stream testbench: clock, reset, APB writes,
// element vectors with random gaps and output stalls, and the final verdict.
// Depends on fdax_pkg, the stream interfaces, the block and fdax_checker.
`default_nettype none

module fused_dot_axpy_stream_tb;
    import fdax_pkg::*;

    localparam int                 ACC_W       = 48;
    localparam int                 CYCLE_LIMIT = 1_000_000;
    localparam int                 HOLD_CYCLES = 300;
    localparam int                 SAT_ITEMS   = 16;
    localparam int                 PHASE_ITEMS = 250;
    localparam logic signed [15:0] QMAX        = 16'sh7fff;
    localparam logic signed [15:0] QMIN        = 16'sh8000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 err_cnt;
    int                 pend_cnt;
    int                 cycle_cnt = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    logic               hold_active;
    event               hold_ev;

    fdax_in_if                         dat_ch ();
    fdax_out_if #(.ACC_WIDTH(ACC_W))   res_ch ();

    fused_dot_axpy_stream #(
        .ACC_WIDTH(ACC_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dat   (dat_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fdax_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dat       (dat_ch),
        .i_res       (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_err_count (err_cnt),
        .o_pending   (pend_cnt)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        hold_active = 1'b0;
        forever begin
            @(hold_ev);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active <= 1'b0;
        end
    end

    function automatic logic signed [15:0] rand_q15();
        case ($urandom_range(7))
            0:       return QMIN;
            1:       return QMAX;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // conj bits: [2] dot x, [1] dot y, [0] axpy x; upper data bits are random
    task automatic apply_config(input logic signed [15:0] a_re, input logic signed [15:0] a_im,
                                input logic [2:0] conj);
        apb_write(REG_ALPHA_RE,    {16'($urandom), a_re});
        apb_write(REG_ALPHA_IM,    {16'($urandom), a_im});
        apb_write(REG_CONJ_DOT_X,  {31'($urandom), conj[2]});
        apb_write(REG_CONJ_DOT_Y,  {31'($urandom), conj[1]});
        apb_write(REG_CONJ_AXPY_X, {31'($urandom), conj[0]});
    endtask

    task automatic send_element(
        input logic signed [15:0] xr, input logic signed [15:0] xi,
        input logic signed [15:0] yr, input logic signed [15:0] yi,
        input logic signed [15:0] zr, input logic signed [15:0] zi,
        input logic               lst
    );
        while ($urandom_range(99) < send_idle_pct) begin
            dat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        dat_ch.valid <= 1'b1;
        dat_ch.x_re  <= xr;
        dat_ch.x_im  <= xi;
        dat_ch.y_re  <= yr;
        dat_ch.y_im  <= yi;
        dat_ch.z_re  <= zr;
        dat_ch.z_im  <= zi;
        dat_ch.last  <= lst;
        @(posedge i_clk);
        while (!dat_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        dat_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic signed [15:0] a_re, input logic signed [15:0] a_im,
                             input logic [2:0] conj, input bit with_hold);
        int  n_sent;
        int  len;
        bit  held;
        n_sent = 0;
        held   = 1'b0;
        wait_idle();
        apply_config(a_re, a_im, conj);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (n_sent < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                send_element(rand_q15(), rand_q15(), rand_q15(), rand_q15(),
                             rand_q15(), rand_q15(), i == len - 1);
            end
            n_sent += len;
            if (with_hold && !held && n_sent >= 40) begin
                -> hold_ev;
                held = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        dat_ch.valid   = 1'b0;
        dat_ch.x_re    = '0;
        dat_ch.x_im    = '0;
        dat_ch.y_re    = '0;
        dat_ch.y_im    = '0;
        dat_ch.z_re    = '0;
        dat_ch.z_im    = '0;
        dat_ch.last    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: z passes through, plain dot product
        send_element(QMAX, QMIN, QMIN, QMAX, QMAX, QMIN, 1'b0);
        send_element(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b1);
        send_element(16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd0, -16'sd1, 1'b1);
        wait_idle();

        apply_config(QMAX, QMIN, 3'b101);
        for (int k = REG_CONJ_AXPY_X + 1; k < 2 ** (PADDR_W - 2); k++) begin
            apb_write(3'(k), $urandom);
        end
        send_element(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_element(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b0);
        send_element(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 1'b0);
        send_element(QMAX, QMIN, QMIN, QMAX, QMAX, QMIN, 1'b0);
        send_element(QMIN, QMAX, QMAX, QMIN, QMIN, QMAX, 1'b1);
        send_element(16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0);
        send_element(-16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1);
        send_element(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b1);
        wait_idle();

        apply_config(QMIN, QMIN, 3'b010);
        send_element(QMIN, QMIN, QMAX, QMIN, QMAX, QMAX, 1'b0);
        send_element(QMAX, QMAX, QMIN, QMAX, QMIN, QMIN, 1'b0);
        send_element(QMIN, 16'sd0, 16'sd0, QMIN, QMIN, 16'sd0, 1'b0);
        send_element(16'sd0, QMAX, QMAX, 16'sd0, 16'sd1, -16'sd1, 1'b1);
        wait_idle();

        // grow the real sum with full-scale terms, then pull it back down
        apply_config(16'sd12345, -16'sd321, 3'b000);
        for (int i = 0; i < SAT_ITEMS; i++) begin
            send_element(QMIN, QMIN, QMIN, QMAX, 16'sd0, 16'sd0, 1'b0);
        end
        send_element(QMIN, 16'sd0, QMAX, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        // grow the imaginary sum negative, then push it back up
        for (int i = 0; i < SAT_ITEMS; i++) begin
            send_element(QMIN, QMAX, QMIN, QMAX, 16'sd0, 16'sd0, 1'b0);
        end
        send_element(QMAX, 16'sd0, 16'sd0, QMAX, 16'sd0, 16'sd0, 1'b1);

        run_phase(0, 0, QMIN, QMIN, 3'b111, 1'b1);
        run_phase(88, 0, QMAX, QMAX, 3'b000, 1'b0);
        run_phase(0, 88, 16'($urandom), 16'($urandom), 3'($urandom), 1'b0);
        run_phase(8, 8, 16'($urandom), 16'($urandom), 3'($urandom), 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/fdax_pkg.sv
rtl/fdax_if.sv
rtl/fdax_regs.sv
rtl/fdax_front.sv
rtl/fdax_queue.sv
rtl/fdax_back.sv
rtl/fused_dot_axpy_stream.sv
verif/fdax_checker.sv
verif/fused_dot_axpy_stream_tb.sv
